// File: sv/lhe_pkg.sv
// ----------------------------------------------------------------------------
// Length header encoder package
// Shared constants, the header format codes and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package lhe_pkg;

  // Width of the message length field.
  localparam int LENGTH_BITS = 16;

  // Most header bytes that one length produces.
  localparam int BYTE_MAX = 4;

  // Decimal and hex digit counts of a length.
  localparam int DEC_DIGITS = 5;
  localparam int HEX_DIGITS = 4;

  // Default depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_HEADER_FORMAT = 1'b0;

  // Division by ten: q = (x * 0xCCCD) >> 19 is exact for every 16-bit x.
  localparam logic [LENGTH_BITS-1:0] DIV10_RECIP = 16'hCCCD;
  localparam int DIV10_SHIFT = 19;

  // Constants of the header formats.
  localparam logic [7:0] FLEX_ESCAPE = 8'hC2;
  localparam logic [LENGTH_BITS-1:0] FLEX_LIMIT = 16'd128;
  localparam logic [LENGTH_BITS-1:0] MINUS_OFFSET = 16'd4;

  // ASCII characters.
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;

  typedef enum logic [3:0] {
    FMT_NONE    = 4'd0,
    FMT_BIN1    = 4'd1,
    FMT_BIN_LE2 = 4'd2,
    FMT_BIN_LE4 = 4'd3,
    FMT_BIN_BE2 = 4'd4,
    FMT_BIN_BE4 = 4'd5,
    FMT_DEC1    = 4'd6,
    FMT_DEC2    = 4'd7,
    FMT_DEC3    = 4'd8,
    FMT_BCD1    = 4'd9,
    FMT_BCD2    = 4'd10,
    FMT_HEX2    = 4'd11,
    FMT_HEX4    = 4'd12,
    FMT_DEC4    = 4'd13,
    FMT_FLEX    = 4'd14,
    FMT_DEC4_M4 = 4'd15
  } fmt_t;

  typedef logic [2:0] cnt_t;

  // One finished header: bytes in wire order (byte 0 first) and their count.
  typedef struct packed {
    logic [BYTE_MAX-1:0][7:0] bytes;
    cnt_t                     cnt;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/lhe_if.sv
// ----------------------------------------------------------------------------
// Length header encoder channel interfaces
// Valid/ready channels for message lengths in and header bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lhe_in_if;
  import lhe_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [LENGTH_BITS-1:0] message_length;

  modport source (output valid, output message_length, input ready);
  modport sink (input valid, input message_length, output ready);
endinterface

interface lhe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       last_byte;

  modport source (output valid, output header_byte, output last_byte, input ready);
  modport sink (input valid, input header_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: sv/lhe_front.sv
// ----------------------------------------------------------------------------
// Length header encoder front end
// Accepts lengths, splits them into decimal digits one stage per digit and
// packs the header bytes of the selected format into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lhe_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  var  lhe_pkg::fmt_t fmt,
  lhe_in_if.sink             in_ch,
  output logic               push_valid,
  input  wire logic          push_ready,
  output lhe_pkg::entry_t    push_data
);
  import lhe_pkg::*;

  localparam int STAGES = DEC_DIGITS + 1;
  localparam int LEN_W  = $clog2(DEC_DIGITS + 1);
  localparam int DPOS_W = $clog2(DEC_DIGITS);
  localparam int HPOS_W = $clog2(HEX_DIGITS);

  typedef struct packed {
    logic [LENGTH_BITS-1:0]           n;
    fmt_t                             fmt;
    logic                             neg;
    logic                             empty;
    logic [LENGTH_BITS-1:0]           rem;
    logic [3:0]                       q1nib;
    logic [DEC_DIGITS-1:0][3:0]       dig;
  } stage_t;

  stage_t                   st_r   [STAGES];
  stage_t                   st_nxt [STAGES];
  logic [STAGES-1:0]        vld_r;
  logic                     advance;
  logic [2*LENGTH_BITS-1:0] prod   [1:STAGES-1];
  logic [LENGTH_BITS-1:0]   quot   [1:STAGES-1];
  logic [LENGTH_BITS-1:0]   rem_d  [1:STAGES-1];
  logic                     in_neg;

  stage_t                   last_st;
  logic [LEN_W-1:0]         nd, nh, dec_w, hex_w, dec_len, hex_len;
  logic [DPOS_W-1:0]        dpos  [BYTE_MAX];
  logic [HPOS_W-1:0]        hpos  [BYTE_MAX];
  logic [3:0]               tdec  [BYTE_MAX];
  logic [3:0]               thex  [BYTE_MAX];
  logic [7:0]               cdec  [BYTE_MAX];
  logic [7:0]               chex  [BYTE_MAX];
  logic [7:0]               n_lo, n_hi;

  // The whole pipe moves unless the oldest item waits on a full queue.
  assign advance     = !vld_r[STAGES-1] || st_r[STAGES-1].empty || push_ready;
  assign in_ch.ready = advance;

  always_comb begin
    in_neg = (fmt == FMT_DEC4_M4) && (in_ch.message_length < MINUS_OFFSET);

    st_nxt[0]       = '0;
    st_nxt[0].n     = in_ch.message_length;
    st_nxt[0].fmt   = fmt;
    st_nxt[0].neg   = in_neg;
    st_nxt[0].empty = (fmt == FMT_NONE);
    st_nxt[0].rem   = ((fmt == FMT_DEC4_M4) && !in_neg) ?
                      in_ch.message_length - MINUS_OFFSET : in_ch.message_length;

    // Each stage peels off the lowest decimal digit of what remains.
    for (int k = 1; k < STAGES; k++) begin
      prod[k]  = st_r[k-1].rem * DIV10_RECIP;
      quot[k]  = LENGTH_BITS'(prod[k] >> DIV10_SHIFT);
      rem_d[k] = st_r[k-1].rem - ((quot[k] << 3) + (quot[k] << 1));
      st_nxt[k]          = st_r[k-1];
      st_nxt[k].rem      = quot[k];
      st_nxt[k].dig[k-1] = rem_d[k][3:0];
      if (k == 1) begin
        st_nxt[k].q1nib = quot[k][3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[STAGES-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Header packing from the last stage.
  always_comb begin
    last_st = st_r[STAGES-1];
    n_lo    = last_st.n[7:0];
    n_hi    = last_st.n[15:8];

    nd = LEN_W'(1);
    for (int i = 1; i < DEC_DIGITS; i++) begin
      if (last_st.dig[i] != 4'd0) nd = LEN_W'(i + 1);
    end
    nh = LEN_W'(1);
    for (int i = 1; i < HEX_DIGITS; i++) begin
      if (last_st.n[4*i +: 4] != 4'd0) nh = LEN_W'(i + 1);
    end

    case (last_st.fmt)
      FMT_DEC1: dec_w = LEN_W'(1);
      FMT_DEC2: dec_w = LEN_W'(2);
      FMT_DEC3: dec_w = LEN_W'(3);
      default:  dec_w = LEN_W'(4);
    endcase
    hex_w   = (last_st.fmt == FMT_HEX2) ? LEN_W'(2) : LEN_W'(4);
    dec_len = (nd > dec_w) ? nd : dec_w;
    hex_len = (nh > hex_w) ? nh : hex_w;

    // Character i of the padded text is digit (length - 1 - i).
    for (int i = 0; i < BYTE_MAX; i++) begin
      dpos[i] = DPOS_W'(dec_len - LEN_W'(i) - LEN_W'(1));
      hpos[i] = HPOS_W'(hex_len - LEN_W'(i) - LEN_W'(1));
      tdec[i] = (dec_len > LEN_W'(i)) ? last_st.dig[dpos[i]] : 4'd0;
      thex[i] = last_st.n[4*hpos[i] +: 4];
      cdec[i] = CHAR_ZERO + 8'(tdec[i]);
      chex[i] = (thex[i] < 4'd10) ? CHAR_ZERO + 8'(thex[i]) : HEX_ALPHA_BASE + 8'(thex[i]);
    end

    push_data = '0;
    case (last_st.fmt)
      FMT_NONE: push_data.cnt = cnt_t'(0);
      FMT_BIN1: begin
        push_data.bytes[0] = n_lo;
        push_data.cnt      = cnt_t'(1);
      end
      FMT_BIN_LE2: begin
        push_data.bytes[0] = n_lo;
        push_data.bytes[1] = n_hi;
        push_data.cnt      = cnt_t'(2);
      end
      FMT_BIN_LE4: begin
        push_data.bytes[0] = n_lo;
        push_data.bytes[1] = n_hi;
        push_data.cnt      = cnt_t'(4);
      end
      FMT_BIN_BE2: begin
        push_data.bytes[0] = n_hi;
        push_data.bytes[1] = n_lo;
        push_data.cnt      = cnt_t'(2);
      end
      FMT_BIN_BE4: begin
        push_data.bytes[2] = n_hi;
        push_data.bytes[3] = n_lo;
        push_data.cnt      = cnt_t'(4);
      end
      FMT_DEC1: begin
        push_data.bytes[0] = cdec[0];
        push_data.cnt      = cnt_t'(1);
      end
      FMT_DEC2: begin
        push_data.bytes[0] = cdec[0];
        push_data.bytes[1] = cdec[1];
        push_data.cnt      = cnt_t'(2);
      end
      FMT_DEC3: begin
        push_data.bytes[0] = cdec[0];
        push_data.bytes[1] = cdec[1];
        push_data.bytes[2] = cdec[2];
        push_data.cnt      = cnt_t'(3);
      end
      FMT_BCD1: begin
        // Binary tens count (low nibble) over the ones digit.
        push_data.bytes[0] = {last_st.q1nib, last_st.dig[0]};
        push_data.cnt      = cnt_t'(1);
      end
      FMT_BCD2: begin
        push_data.bytes[0] = {tdec[0], tdec[1]};
        push_data.bytes[1] = {tdec[2], tdec[3]};
        push_data.cnt      = cnt_t'(2);
      end
      FMT_HEX2: begin
        push_data.bytes[0] = chex[0];
        push_data.bytes[1] = chex[1];
        push_data.cnt      = cnt_t'(2);
      end
      FMT_HEX4: begin
        for (int i = 0; i < BYTE_MAX; i++) push_data.bytes[i] = chex[i];
        push_data.cnt = cnt_t'(4);
      end
      FMT_DEC4: begin
        for (int i = 0; i < BYTE_MAX; i++) push_data.bytes[i] = cdec[i];
        push_data.cnt = cnt_t'(4);
      end
      FMT_FLEX: begin
        if (last_st.n > FLEX_LIMIT) begin
          push_data.bytes[0] = FLEX_ESCAPE;
          push_data.bytes[1] = n_lo;
          push_data.bytes[2] = n_hi;
          push_data.cnt      = cnt_t'(3);
        end else begin
          push_data.bytes[0] = n_lo;
          push_data.bytes[1] = n_hi;
          push_data.cnt      = cnt_t'(2);
        end
      end
      FMT_DEC4_M4: begin
        if (last_st.neg) begin
          push_data.bytes[0] = CHAR_MINUS;
          push_data.bytes[1] = CHAR_ZERO;
          push_data.bytes[2] = CHAR_ZERO;
          push_data.bytes[3] = CHAR_ZERO;
        end else begin
          for (int i = 0; i < BYTE_MAX; i++) push_data.bytes[i] = cdec[i];
        end
        push_data.cnt = cnt_t'(4);
      end
      default: push_data.cnt = cnt_t'(0);
    endcase
  end

  // Lengths with no header bytes are dropped here.
  assign push_valid = vld_r[STAGES-1] && !last_st.empty;

endmodule

`default_nettype wire

// File: sv/lhe_queue.sv
// ----------------------------------------------------------------------------
// Length header encoder queue
// Small FIFO of packed headers between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lhe_queue #(
  parameter int DEPTH = lhe_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push_valid,
  output logic            push_ready,
  input  var  lhe_pkg::entry_t push_data,
  output logic            pop_valid,
  input  wire logic       pop_ready,
  output lhe_pkg::entry_t pop_data
);
  import lhe_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/lhe_back.sv
// ----------------------------------------------------------------------------
// Length header encoder back end
// Sends the bytes of each queued header one per cycle while out_ch is ready,
// through an output register, and marks the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lhe_back (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       pop_valid,
  output logic            pop_ready,
  input  var  lhe_pkg::entry_t pop_data,
  lhe_out_if.source       out_ch
);
  import lhe_pkg::*;

  localparam int IDX_W = $clog2(BYTE_MAX);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             load, is_last;

  assign load    = pop_valid && (!out_valid_r || out_ch.ready);
  assign is_last = (cnt_t'(idx_r) == pop_data.cnt - cnt_t'(1));

  // The queue entry leaves once its final byte has moved to the output.
  assign pop_ready = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      idx_nxt       = is_last ? '0 : idx_r + IDX_W'(1);
      out_valid_nxt = 1'b1;
      out_byte_nxt  = pop_data.bytes[idx_r];
      out_last_nxt  = is_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.header_byte = out_byte_r;
  assign out_ch.last_byte   = out_last_r;

endmodule

`default_nettype wire

// File: sv/length_header_encoder_top.sv
// ----------------------------------------------------------------------------
// Length header encoder
// Turns each message length into the bytes of a length-prefix header in one
// of sixteen formats chosen by the header_format register (address 0): none,
// 1/2/4-byte little-endian or 2/4-byte big-endian binary, 1 to 4 zero-padded
// ASCII decimal digits (a longer number keeps its leading digits), packed BCD
// in 1 or 2 bytes, 2 or 4 uppercase ASCII hex digits, a flexible form with a
// 0xC2 escape above 128, and four decimal digits of the length minus four.
// Lengths enter on in_ch and the header leaves on out_ch one byte per cycle,
// with last_byte set on its final byte; the none format produces no bytes.
// The front end accepts one length per cycle whenever its queue has room,
// splitting the length into decimal digits over five pipeline stages and
// packing the header into a four-entry queue. The back end sends one byte
// per cycle while out_ch is ready, so a header of N bytes (0 to 4) holds
// the output for its N bytes, which sets the sustained rate of lengths.
// A length reaches the output through the front-end stages, the queue and
// the output register. Write header_format only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module length_header_encoder_top #(
  parameter int QUEUE_DEPTH = lhe_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lhe_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [lhe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [lhe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  lhe_in_if.sink                              in_ch,
  lhe_out_if.source                           out_ch
);
  import lhe_pkg::*;

  fmt_t   fmt_r, fmt_nxt;
  logic   reg_hit;
  logic   push_valid, push_ready;
  entry_t push_data;
  logic   pop_valid, pop_ready;
  entry_t pop_data;

  // The register space holds one word; the byte offset inside it is ignored.
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_IDX_HEADER_FORMAT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? CFG_DATA_W'(fmt_r) : '0;

  always_comb begin
    fmt_nxt = fmt_r;
    if (psel && penable && pwrite && reg_hit) begin
      fmt_nxt = fmt_t'(pwdata[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_NONE;
    end else begin
      fmt_r <= fmt_nxt;
    end
  end

  // The front end classifies each length and builds its header bytes.
  lhe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .fmt        (fmt_r),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The queue lets the front keep accepting while bytes drain at the output.
  lhe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end serializes each header onto the output channel.
  lhe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // Every header reaching the queue carries between one and four bytes.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (push_data.cnt != cnt_t'(0) && push_data.cnt <= cnt_t'(BYTE_MAX)))
    else $error("queued header has a byte count out of range");

  // The input only stalls when the front holds a header the queue cannot take.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (push_valid && !push_ready))
    else $error("input stalled without a full queue");

  // A queue entry is released only when it is present.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ready |-> pop_valid)
    else $error("queue popped while empty");

  // Reset leaves the output channel empty.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

// File: tb/lhe_header_checker.sv
// ----------------------------------------------------------------------------
// Length header encoder checker
// Watches the configuration port and both channels. It predicts the header
// bytes of every accepted length, compares each emitted byte with the
// oldest prediction, and reports mismatches and the number still pending.
// ----------------------------------------------------------------------------
module lhe_header_checker
  import lhe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  lhe_in_if                          in_mon,
  lhe_out_if                         out_mon,
  output int                         mismatch_count,
  output int                         bytes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] HEADER_FORMAT_ADDR = CFG_ADDR_W'(4 * REG_IDX_HEADER_FORMAT);

  typedef struct packed {
    logic [7:0] header_byte;
    logic       last_byte;
  } hdr_byte_t;

  fmt_t      header_fmt = FMT_NONE;
  hdr_byte_t expected_header [$];
  int        fails = 0;
  int        pending_bytes = 0;

  assign mismatch_count = fails;
  assign bytes_pending  = pending_bytes;

  // Character at position pos of v written in the given radix, zero-padded
  // to min_width digits. Longer numbers keep all their digits, so position
  // zero is always the most significant one.
  function automatic logic [7:0] text_char(input int unsigned v, input int unsigned radix,
                                           input int unsigned min_width,
                                           input int unsigned pos);
    logic [7:0]  rev [24];
    int unsigned nd;
    int unsigned d;
    nd = 0;
    do begin
      d       = v % radix;
      rev[nd] = (d < 10) ? CHAR_ZERO + 8'(d) : HEX_ALPHA_BASE + 8'(d);
      nd++;
      v = v / radix;
    end while (v != 0);
    while (nd < min_width) begin
      rev[nd] = CHAR_ZERO;
      nd++;
    end
    return rev[nd - 1 - pos];
  endfunction

  // Header bytes of one length in wire order; returns how many there are.
  function automatic int encode_header(input fmt_t f, input logic [LENGTH_BITS-1:0] n,
                                       output logic [BYTE_MAX-1:0][7:0] hb);
    int unsigned radix;
    int unsigned min_width;
    int unsigned value;
    int unsigned bcd;
    int          cnt;
    logic [3:0]  dig [4];
    hb        = '0;
    cnt       = 0;
    radix     = 0;
    min_width = 0;
    value     = n;
    case (f)
      FMT_BIN1: begin
        hb[0] = n[7:0];
        cnt   = 1;
      end
      FMT_BIN_LE2, FMT_BIN_LE4: begin
        hb[0] = n[7:0];
        hb[1] = n[15:8];
        cnt   = (f == FMT_BIN_LE2) ? 2 : 4;
      end
      FMT_BIN_BE2: begin
        hb[0] = n[15:8];
        hb[1] = n[7:0];
        cnt   = 2;
      end
      FMT_BIN_BE4: begin
        hb[2] = n[15:8];
        hb[3] = n[7:0];
        cnt   = 4;
      end
      FMT_DEC1: begin radix = 10; min_width = 1; cnt = 1; end
      FMT_DEC2: begin radix = 10; min_width = 2; cnt = 2; end
      FMT_DEC3: begin radix = 10; min_width = 3; cnt = 3; end
      FMT_DEC4: begin radix = 10; min_width = 4; cnt = 4; end
      FMT_HEX2: begin radix = 16; min_width = 2; cnt = 2; end
      FMT_HEX4: begin radix = 16; min_width = 4; cnt = 4; end
      FMT_BCD1: begin
        bcd   = (value / 10) * 16 + value % 10;
        hb[0] = bcd[7:0];
        cnt   = 1;
      end
      FMT_BCD2: begin
        for (int k = 0; k < 4; k++) dig[k] = 4'(text_char(value, 10, 4, k) - CHAR_ZERO);
        hb[0] = {dig[0], dig[1]};
        hb[1] = {dig[2], dig[3]};
        cnt   = 2;
      end
      FMT_FLEX: begin
        if (n > FLEX_LIMIT) begin
          hb[0] = FLEX_ESCAPE;
          hb[1] = n[7:0];
          hb[2] = n[15:8];
          cnt   = 3;
        end else begin
          hb[0] = n[7:0];
          hb[1] = n[15:8];
          cnt   = 2;
        end
      end
      FMT_DEC4_M4: begin
        if (n < MINUS_OFFSET) begin
          // A negative result shows as a minus sign and the first three
          // padded digits, which are always zero.
          hb  = {CHAR_ZERO, CHAR_ZERO, CHAR_ZERO, CHAR_MINUS};
          cnt = 4;
        end else begin
          value     = n - MINUS_OFFSET;
          radix     = 10;
          min_width = 4;
          cnt       = 4;
        end
      end
      default: cnt = 0;
    endcase
    if (radix != 0) begin
      for (int k = 0; k < cnt; k++) hb[k] = text_char(value, radix, min_width, k);
    end
    return cnt;
  endfunction

  always @(posedge clk) begin : monitor
    logic [BYTE_MAX-1:0][7:0] hb;
    int                       cnt;
    hdr_byte_t                want;
    if (!rst_n) begin
      header_fmt = FMT_NONE;
      expected_header.delete();
    end else begin
      // A length accepted on the same edge as a register write still sees
      // the old format.
      if (in_mon.valid && in_mon.ready) begin
        cnt = encode_header(header_fmt, in_mon.message_length, hb);
        for (int k = 0; k < cnt; k++) expected_header.push_back('{hb[k], k == cnt - 1});
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_header.size() == 0) begin
          $display("%0t: unexpected header byte 0x%02h (last %0b), none expected",
                   $time, out_mon.header_byte, out_mon.last_byte);
          fails++;
        end else begin
          want = expected_header.pop_front();
          if (out_mon.header_byte !== want.header_byte) begin
            $display("%0t: header_byte mismatch, expected 0x%02h, actual 0x%02h",
                     $time, want.header_byte, out_mon.header_byte);
            fails++;
          end
          if (out_mon.last_byte !== want.last_byte) begin
            $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                     $time, want.last_byte, out_mon.last_byte);
            fails++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == HEADER_FORMAT_ADDR)
        header_fmt = fmt_t'(pwdata[3:0]);
    end
    pending_bytes <= expected_header.size();
  end

endmodule

// File: tb/tb_length_header_encoder_top.sv
// ----------------------------------------------------------------------------
// Length header encoder testbench
// Runs every header format: a directed pass over the corner lengths of each
// format, then random lengths under each format in shuffled order, with
// random stalls on both channels and one long output hold-off that backs
// the block up. A separate checker predicts and compares every header byte.
// ----------------------------------------------------------------------------
module tb_length_header_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lhe_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] HEADER_FORMAT_ADDR = CFG_ADDR_W'(4 * REG_IDX_HEADER_FORMAT);

  // A length crosses the front-end stages, queue and output register before
  // its first byte leaves; a no-byte header may still sit in the front end.
  localparam int SETTLE_CYCLES  = 16;
  // Cycles the receiver refuses bytes during the back-pressure phase.
  localparam int LONG_HOLD      = 80;
  // Cycles without any accepted item before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 12;

  // Lengths near the decimal, BCD, flexible and minus-four boundaries.
  localparam logic [LENGTH_BITS-1:0] CORNER_LENGTHS [21] = '{
    16'd0, 16'd1, 16'd3, 16'd4, 16'd5, 16'd99, 16'd100, 16'd127, 16'd128, 16'd129,
    16'd255, 16'd256, 16'd999, 16'd1000, 16'd1003, 16'd1004, 16'd9999, 16'd10000,
    16'd10003, 16'd10004, 16'd65535
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  lhe_in_if  in_ch ();
  lhe_out_if out_ch ();

  // Stimulus modes shared by the sender and the receiver. calm turns off
  // idling on both sides, steady only on the sender side.
  bit calm         = 1'b0;
  bit steady       = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;

  int hdr_mismatches;
  int hdr_pending;
  int idle_cycles = 0;

  length_header_encoder_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  lhe_header_checker hdr_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (hdr_mismatches),
    .bytes_pending  (hdr_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The watchdog ends a run in which neither channel moves an item for too
  // long. The longest legal quiet stretch is the output hold-off.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: alternates stretches of readiness with short random stalls.
  // When the stimulus asks for it, it refuses bytes for a long stretch so
  // that the queue fills and the block stops taking lengths.
  initial begin : receiver
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 6);
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Random length: a mix of full-range values, small values where the
  // padding matters, and values at the format boundaries.
  function automatic logic [LENGTH_BITS-1:0] random_length();
    case ($urandom_range(0, 4))
      0:       return LENGTH_BITS'($urandom_range(0, 200));
      1:       return CORNER_LENGTHS[$urandom_range(0, 20)];
      2:       return LENGTH_BITS'($urandom_range(0, 12000));
      default: return LENGTH_BITS'($urandom());
    endcase
  endfunction

  // Offers one length, sometimes after a short gap, and returns at the
  // edge at which it is accepted. valid stays high into the next item.
  task automatic send_length(input logic [LENGTH_BITS-1:0] len);
    int gap;
    if (!calm && !steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.message_length <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops offering lengths and waits until every predicted byte has come
  // out, plus enough cycles for a header with no bytes to clear the pipe.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (hdr_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes header_format once the block has gone idle: a setup cycle, then
  // an access cycle that completes when pready is high.
  task automatic set_format(input fmt_t f);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HEADER_FORMAT_ADDR;
    pwdata  <= CFG_DATA_W'(f);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    fmt_t order [16];
    fmt_t tmp;
    int   j;
    rst_n                <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.message_length <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass: each format once with the lengths that hit its corner
    // cases. The none format must swallow the length without output.
    set_format(FMT_NONE);
    send_length(16'hFFFF);
    set_format(FMT_BIN1);
    send_length(16'd255);
    set_format(FMT_BIN_LE2);
    send_length(16'hFFFF);
    set_format(FMT_BIN_LE4);
    send_length(16'hA55A);
    set_format(FMT_BIN_BE2);
    send_length(16'h00FF);
    set_format(FMT_BIN_BE4);
    send_length(16'hFFFF);
    // A single decimal character is the leading digit, and zero gives '0'.
    set_format(FMT_DEC1);
    send_length(16'd0);
    send_length(16'd65535);
    // Short decimal and hex forms keep the most significant characters of
    // a number that is too long for them.
    set_format(FMT_DEC2);
    send_length(16'd7);
    send_length(16'd65535);
    set_format(FMT_DEC3);
    send_length(16'd42);
    send_length(16'd12345);
    // One-byte BCD leaves decimal once the length passes 99: the tens nibble counts on in binary.
    set_format(FMT_BCD1);
    send_length(16'd99);
    send_length(16'd100);
    set_format(FMT_BCD2);
    send_length(16'd65535);
    set_format(FMT_HEX2);
    send_length(16'h000A);
    send_length(16'hBEEF);
    set_format(FMT_HEX4);
    send_length(16'hFACE);
    set_format(FMT_DEC4);
    send_length(16'd65535);
    // The flexible form adds its escape byte only above 128.
    set_format(FMT_FLEX);
    send_length(16'd128);
    send_length(16'd129);
    // Lengths below four give a negative value shown as '-' and zeros.
    set_format(FMT_DEC4_M4);
    send_length(16'd0);
    send_length(16'd3);
    send_length(16'd4);
    send_length(16'd65535);

    // Back-pressure: four-byte headers offered back to back while the
    // receiver holds off, so the queue fills and the input stalls.
    set_format(FMT_HEX4);
    steady       = 1'b1;
    hold_request = 1'b1;
    repeat (20) send_length(random_length());
    steady = 1'b0;

    // Random pass: every format once in shuffled order. The last two
    // phases run with no idling on either side.
    for (int i = 0; i < 16; i++) order[i] = fmt_t'(i);
    for (int i = 15; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 16; i++) begin
      if (i >= 14) calm = 1'b1;
      set_format(order[i]);
      repeat (PHASE_ITEMS) send_length(random_length());
    end

    drain();
    if (hdr_mismatches == 0 && hdr_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
